// ===== hdl/message_segmenter_core_assert.svh =====
// Assertion macros shared by the segmenter modules.
// Each expects signals named clk and rst in the scope of use.
`ifndef MESSAGE_SEGMENTER_CORE_ASSERT_SVH
`define MESSAGE_SEGMENTER_CORE_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define MSGSEG_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define MSGSEG_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== hdl/msgseg_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
package msgseg_pkg;

  localparam int PAYLOAD_BYTES = 32;
  localparam int OFFSET_W      = 6;
  localparam logic [OFFSET_W-1:0] LAST_POS = OFFSET_W'(PAYLOAD_BYTES - 1);

  localparam int LENGTH_W = 32;
  localparam int ELEM_W   = 16;
  localparam int PACKET_W = 32;

  localparam int CFG_INDEX_W = 1;
  localparam int CFG_DATA_W  = 32;

  localparam int QUEUE_DEPTH = 4;
  localparam int QUEUE_PTR_W = $clog2(QUEUE_DEPTH);
  localparam int QUEUE_CNT_W = $clog2(QUEUE_DEPTH + 1);

  typedef enum logic [CFG_INDEX_W-1:0] {
    REG_MESSAGE_LENGTH = 1'b0,
    REG_ELEMENT_SIZE   = 1'b1
  } reg_index_t;

  typedef enum logic {
    BACK_DATA = 1'b0,
    BACK_PAD  = 1'b1
  } back_state_t;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       last_byte;
  } q_entry_t;

  typedef struct packed {
    logic     valid;
    q_entry_t entry;
  } q_port_t;

  typedef struct packed {
    logic [LENGTH_W-1:0] header_total_length;
    logic [ELEM_W-1:0]   header_element_size;
    logic [PACKET_W-1:0] packet_number;
    logic [OFFSET_W-1:0] byte_offset;
    logic [7:0]          payload_byte;
    logic                is_padding;
    logic                last_in_packet;
    logic                last_of_message;
  } beat_t;

endpackage
`default_nettype wire

// ===== hdl/msgseg_byte_if.sv =====
`timescale 1ns / 1ps
`default_nettype none
interface msgseg_byte_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;

  modport source (output valid, output data_byte, input ready);
  modport sink (input valid, input data_byte, output ready);
endinterface
`default_nettype wire

// ===== hdl/msgseg_beat_if.sv =====
`timescale 1ns / 1ps
`default_nettype none
interface msgseg_beat_if;
  import msgseg_pkg::*;

  logic  valid;
  logic  ready;
  beat_t beat;

  modport source (output valid, output beat, input ready);
  modport sink (input valid, input beat, output ready);
endinterface
`default_nettype wire

// ===== hdl/msgseg_front.sv =====
`timescale 1ns / 1ps
`default_nettype none
module msgseg_front (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic                          clear,
  input  wire logic [msgseg_pkg::LENGTH_W-1:0] message_length,
  input  wire logic                          q_full,
  output msgseg_pkg::q_port_t                push,
  msgseg_byte_if.sink                        message
);
  import msgseg_pkg::*;

  logic [LENGTH_W-1:0] bytes_taken;
  logic [LENGTH_W-1:0] bytes_taken_next;
  logic                accepted;
  logic                keep;

  assign message.ready = !q_full;
  assign accepted      = message.valid && message.ready;
  assign keep          = bytes_taken < message_length;

  // Bytes past the configured length, or any byte of an empty message, are dropped.
  assign bytes_taken_next = bytes_taken + LENGTH_W'(1);

  assign push.valid           = accepted && keep;
  assign push.entry.data_byte = message.data_byte;
  assign push.entry.last_byte = bytes_taken_next == message_length;

  always_ff @(posedge clk) begin
    if (rst || clear) begin
      bytes_taken <= '0;
    end else if (push.valid) begin
      bytes_taken <= bytes_taken_next;
    end
  end
endmodule
`default_nettype wire

// ===== hdl/msgseg_queue.sv =====
`timescale 1ns / 1ps
`default_nettype none
module msgseg_queue (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          clear,
  input  msgseg_pkg::q_port_t push,
  input  wire logic          pop,
  output msgseg_pkg::q_port_t head,
  output logic               full
);
  import msgseg_pkg::*;

  q_entry_t                store [QUEUE_DEPTH];
  logic [QUEUE_PTR_W-1:0]  wr_ptr;
  logic [QUEUE_PTR_W-1:0]  rd_ptr;
  logic [QUEUE_CNT_W-1:0]  count;
  logic                    do_push;
  logic                    do_pop;

  assign full       = count == QUEUE_CNT_W'(QUEUE_DEPTH);
  assign head.valid = count != '0;
  assign head.entry = store[rd_ptr];
  assign do_push    = push.valid && !full;
  assign do_pop     = pop && head.valid;

  always_ff @(posedge clk) begin
    if (do_push) begin
      store[wr_ptr] <= push.entry;
    end
  end

  always_ff @(posedge clk) begin
    if (rst || clear) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == QUEUE_PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == QUEUE_PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      unique case ({do_push, do_pop})
        2'b10:   count <= count + 1'b1;
        2'b01:   count <= count - 1'b1;
        default: count <= count;
      endcase
    end
  end
endmodule
`default_nettype wire

// ===== hdl/msgseg_back.sv =====
`timescale 1ns / 1ps
`default_nettype none
`include "message_segmenter_core_assert.svh"
module msgseg_back (
  input  wire logic                            clk,
  input  wire logic                            rst,
  input  wire logic                            clear,
  input  wire logic [msgseg_pkg::LENGTH_W-1:0] message_length,
  input  wire logic [msgseg_pkg::ELEM_W-1:0]   elem_size,
  input  msgseg_pkg::q_port_t                  head,
  output logic                                 pop,
  msgseg_beat_if.source                        segments
);
  import msgseg_pkg::*;

  back_state_t         state;
  back_state_t         state_next;
  logic [OFFSET_W-1:0] offset_in_packet;
  logic [OFFSET_W-1:0] offset_next;
  logic [PACKET_W-1:0] current_packet;
  logic [PACKET_W-1:0] packet_next;
  logic                out_valid;
  beat_t               beat;
  beat_t               beat_next;
  logic                slot_free;
  logic                full;
  logic                load;

  assign slot_free      = !out_valid || segments.ready;
  assign full           = offset_in_packet == LAST_POS;
  assign segments.valid = out_valid;
  assign segments.beat  = beat;

  always_ff @(posedge clk) begin
    if (rst || clear) begin
      state <= BACK_DATA;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next  = state;
    offset_next = offset_in_packet;
    packet_next = current_packet;
    pop         = 1'b0;
    load        = 1'b0;
    beat_next   = beat;
    beat_next.header_total_length = message_length;
    beat_next.header_element_size = elem_size;
    beat_next.packet_number       = current_packet;
    beat_next.byte_offset         = offset_in_packet;
    unique case (state)
      BACK_DATA: begin
        if (slot_free && head.valid) begin
          pop  = 1'b1;
          load = 1'b1;
          beat_next.payload_byte    = head.entry.data_byte;
          beat_next.is_padding      = 1'b0;
          beat_next.last_in_packet  = full;
          beat_next.last_of_message = head.entry.last_byte && full;
          if (head.entry.last_byte && !full) begin
            offset_next = offset_in_packet + 1'b1;
            state_next  = BACK_PAD;
          end else if (full) begin
            offset_next = '0;
            packet_next = current_packet + 1'b1;
          end else begin
            offset_next = offset_in_packet + 1'b1;
          end
        end
      end
      BACK_PAD: begin
        if (slot_free) begin
          load = 1'b1;
          beat_next.payload_byte    = '0;
          beat_next.is_padding      = 1'b1;
          beat_next.last_in_packet  = full;
          beat_next.last_of_message = full;
          if (full) begin
            offset_next = '0;
            packet_next = current_packet + 1'b1;
            state_next  = BACK_DATA;
          end else begin
            offset_next = offset_in_packet + 1'b1;
          end
        end
      end
      default: begin
        state_next = BACK_DATA;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst || clear) begin
      offset_in_packet <= '0;
      current_packet   <= '0;
      out_valid        <= 1'b0;
    end else begin
      offset_in_packet <= offset_next;
      current_packet   <= packet_next;
      if (load) begin
        out_valid <= 1'b1;
      end else if (segments.ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      beat <= beat_next;
    end
  end

  `MSGSEG_ASSERT_NOW(a_offset_range, 1'b1, offset_in_packet <= LAST_POS,
                     "offset past packet end")
  `MSGSEG_ASSERT_NOW(a_no_pop_in_pad, state == BACK_PAD, !pop, "queue popped while padding")
  `MSGSEG_ASSERT_NOW(a_lom_ends_packet, out_valid && beat.last_of_message,
                     beat.last_in_packet, "message end inside a packet")
  `MSGSEG_ASSERT_NEXT(a_pad_done, state == BACK_PAD && slot_free && full,
                      state == BACK_DATA && offset_in_packet == '0,
                      "padding did not close the packet")
endmodule
`default_nettype wire

// ===== hdl/message_segmenter_core.sv =====
`timescale 1ns / 1ps
`default_nettype none
// Channel    Kind          Payload
// message    stream in     data_byte, one message byte per beat
// segments   stream out    beat: header, packet number, offset, byte, flags
// cfg_*      write port    0 message length, 1 element size
//
// Bytes are taken one per cycle while the four-entry queue has room.
// The output stage sends one beat per cycle while the sink is ready; a byte passes the queue, then the output register.
// The final byte is followed by up to 31 padding beats, one per cycle while the sink is ready, before the next message.
// Reset is synchronous; any register write clears the position and the queue.
// A stall on the output fills the queue and then holds ready low on the input.
module message_segmenter_core (
  input  wire logic                              clk,
  input  wire logic                              rst,
  input  wire logic                              cfg_write,
  input  wire logic [msgseg_pkg::CFG_INDEX_W-1:0] cfg_index,
  input  wire logic [msgseg_pkg::CFG_DATA_W-1:0]  cfg_data,
  msgseg_byte_if.sink                            message,
  msgseg_beat_if.source                          segments
);
  import msgseg_pkg::*;

  logic [LENGTH_W-1:0] message_length;
  logic [ELEM_W-1:0]   elem_size;
  q_port_t             push;
  q_port_t             head;
  logic                pop;
  logic                q_full;

  always_ff @(posedge clk) begin
    if (rst) begin
      message_length <= '0;
      elem_size      <= ELEM_W'(1);
    end else if (cfg_write) begin
      unique case (reg_index_t'(cfg_index))
        REG_MESSAGE_LENGTH: message_length <= cfg_data[LENGTH_W-1:0];
        REG_ELEMENT_SIZE:   elem_size      <= cfg_data[ELEM_W-1:0];
      endcase
    end
  end

  msgseg_front u_front (
    .clk            (clk),
    .rst            (rst),
    .clear          (cfg_write),
    .message_length (message_length),
    .q_full         (q_full),
    .push           (push),
    .message        (message)
  );

  msgseg_queue u_queue (
    .clk   (clk),
    .rst   (rst),
    .clear (cfg_write),
    .push  (push),
    .pop   (pop),
    .head  (head),
    .full  (q_full)
  );

  msgseg_back u_back (
    .clk            (clk),
    .rst            (rst),
    .clear          (cfg_write),
    .message_length (message_length),
    .elem_size      (elem_size),
    .head           (head),
    .pop            (pop),
    .segments       (segments)
  );
endmodule
`default_nettype wire

// ===== bench/tb_top.sv =====
`timescale 1ns / 1ps
module tb_top;
  import msgseg_pkg::*;

  localparam int ITEMS_TARGET    = 280;
  localparam int SETTLE_CYCLES   = 40;
  localparam int HOLD_OFF_CYCLES = 80;
  localparam int WATCHDOG_LIMIT  = 2000;
  localparam int MAX_REPORTS     = 50;

  typedef enum bit {ROW_WRITE, ROW_BYTE} row_kind_t;

  typedef struct {
    row_kind_t   kind;
    reg_index_t  index;
    logic [31:0] value;
    bit          typed;
    beat_t       want;
  } stim_row_t;

  logic                   clk = 1'b0;
  logic                   rst;
  logic                   cfg_write;
  logic [CFG_INDEX_W-1:0] cfg_index;
  logic [CFG_DATA_W-1:0]  cfg_data;

  msgseg_byte_if msg_bus ();
  msgseg_beat_if seg_bus ();

  message_segmenter_core u_dut (
    .clk       (clk),
    .rst       (rst),
    .cfg_write (cfg_write),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .message   (msg_bus),
    .segments  (seg_bus)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Predictor state: configuration and position in the current message.
  logic [LENGTH_W-1:0] cfg_len    = '0;
  logic [ELEM_W-1:0]   cfg_elem   = 16'd1;
  logic [LENGTH_W-1:0] byte_count = '0;
  logic [PACKET_W-1:0] packet_idx = '0;
  logic [OFFSET_W-1:0] pkt_offset = '0;

  beat_t pending_beats[$];
  int    mismatches    = 0;
  int    live_bytes    = 0;
  int    beats_seen    = 0;
  int    tx_idle_pct   = 20;
  int    rx_idle_pct   = 20;
  bit    no_idle       = 1'b0;
  bit    hold_off_req  = 1'b0;

  stim_row_t directed [21] = '{
    '{ROW_BYTE,  REG_MESSAGE_LENGTH, 32'hA5,        1'b0, '0},
    '{ROW_WRITE, REG_MESSAGE_LENGTH, 32'd1,         1'b0, '0},
    '{ROW_BYTE,  REG_MESSAGE_LENGTH, 32'hFF,        1'b1,
      '{32'd1, 16'd1, 32'd0, 6'd0, 8'hFF, 1'b0, 1'b0, 1'b0}},
    '{ROW_BYTE,  REG_MESSAGE_LENGTH, 32'h00,        1'b0, '0},
    '{ROW_WRITE, REG_ELEMENT_SIZE,   32'hABCD_FFFF, 1'b0, '0},
    '{ROW_WRITE, REG_MESSAGE_LENGTH, 32'hFFFF_FFFF, 1'b0, '0},
    '{ROW_BYTE,  REG_MESSAGE_LENGTH, 32'h00,        1'b1,
      '{32'hFFFF_FFFF, 16'hFFFF, 32'd0, 6'd0, 8'h00, 1'b0, 1'b0, 1'b0}},
    '{ROW_BYTE,  REG_MESSAGE_LENGTH, 32'h80,        1'b0, '0},
    '{ROW_BYTE,  REG_MESSAGE_LENGTH, 32'h01,        1'b0, '0},
    '{ROW_BYTE,  REG_MESSAGE_LENGTH, 32'h7F,        1'b0, '0},
    '{ROW_BYTE,  REG_MESSAGE_LENGTH, 32'hFE,        1'b0, '0},
    '{ROW_BYTE,  REG_MESSAGE_LENGTH, 32'h55,        1'b0, '0},
    '{ROW_WRITE, REG_ELEMENT_SIZE,   32'h0000_0000, 1'b0, '0},
    '{ROW_BYTE,  REG_MESSAGE_LENGTH, 32'h3C,        1'b1,
      '{32'hFFFF_FFFF, 16'h0000, 32'd0, 6'd0, 8'h3C, 1'b0, 1'b0, 1'b0}},
    '{ROW_WRITE, REG_MESSAGE_LENGTH, 32'd2,         1'b0, '0},
    '{ROW_BYTE,  REG_MESSAGE_LENGTH, 32'h11,        1'b1,
      '{32'd2, 16'h0000, 32'd0, 6'd0, 8'h11, 1'b0, 1'b0, 1'b0}},
    '{ROW_BYTE,  REG_MESSAGE_LENGTH, 32'h22,        1'b0, '0},
    '{ROW_BYTE,  REG_MESSAGE_LENGTH, 32'h33,        1'b0, '0},
    '{ROW_WRITE, REG_MESSAGE_LENGTH, 32'd0,         1'b0, '0},
    '{ROW_BYTE,  REG_MESSAGE_LENGTH, 32'hC3,        1'b0, '0},
    '{ROW_WRITE, REG_ELEMENT_SIZE,   32'd1,         1'b0, '0}
  };

  function automatic beat_t make_beat(input logic [7:0] b, input logic pad,
                                      input logic lip, input logic lom);
    beat_t bt;
    bt.header_total_length = cfg_len;
    bt.header_element_size = cfg_elem;
    bt.packet_number       = packet_idx;
    bt.byte_offset         = pkt_offset;
    bt.payload_byte        = b;
    bt.is_padding          = pad;
    bt.last_in_packet      = lip;
    bt.last_of_message     = lom;
    return bt;
  endfunction

  function automatic void step_position();
    if (pkt_offset == LAST_POS) begin
      pkt_offset = '0;
      packet_idx = packet_idx + 1'b1;
    end else begin
      pkt_offset = pkt_offset + 1'b1;
    end
  endfunction

  // Queues the beats that one message byte produces and returns their count.
  function automatic int segment_byte(input logic [7:0] b);
    int   n;
    logic last_byte;
    logic full;
    n = 0;
    if (cfg_len == '0 || byte_count >= cfg_len) begin
      return 0;
    end
    byte_count = byte_count + 1'b1;
    last_byte  = (byte_count == cfg_len);
    full       = (pkt_offset == LAST_POS);
    pending_beats.push_back(make_beat(b, 1'b0, full, last_byte && full));
    n++;
    if (last_byte && !full) begin
      step_position();
      do begin
        full = (pkt_offset == LAST_POS);
        pending_beats.push_back(make_beat(8'h00, 1'b1, full, full));
        n++;
        if (!full) begin
          step_position();
        end
      end while (!full);
      pkt_offset = '0;
      packet_idx = packet_idx + 1'b1;
    end else begin
      step_position();
    end
    return n;
  endfunction

  task automatic flag_error(input string msg);
    if (mismatches < MAX_REPORTS) begin
      $display("ERROR at %0t: %s", $time, msg);
    end
    mismatches++;
  endtask

  task automatic compare_field(input string name, input logic [31:0] got,
                               input logic [31:0] want);
    if (got !== want) begin
      flag_error($sformatf("beat %0d: %s is %0h, expected %0h", beats_seen, name, got, want));
    end
  endtask

  task automatic check_beat(input beat_t got);
    beat_t want;
    if (pending_beats.size() == 0) begin
      flag_error($sformatf("beat %0d arrived with none pending: %h", beats_seen, got));
      return;
    end
    want = pending_beats.pop_front();
    compare_field("header_total_length", got.header_total_length, want.header_total_length);
    compare_field("header_element_size", 32'(got.header_element_size),
                  32'(want.header_element_size));
    compare_field("packet_number", got.packet_number, want.packet_number);
    compare_field("byte_offset", 32'(got.byte_offset), 32'(want.byte_offset));
    compare_field("payload_byte", 32'(got.payload_byte), 32'(want.payload_byte));
    compare_field("is_padding", 32'(got.is_padding), 32'(want.is_padding));
    compare_field("last_in_packet", 32'(got.last_in_packet), 32'(want.last_in_packet));
    compare_field("last_of_message", 32'(got.last_of_message), 32'(want.last_of_message));
  endtask

  always @(posedge clk) begin
    if (!rst && seg_bus.valid && seg_bus.ready) begin
      check_beat(seg_bus.beat);
      beats_seen++;
    end
  end

  initial begin : segments_sink
    seg_bus.ready = 1'b0;
    forever begin
      @(posedge clk);
      if (hold_off_req) begin
        hold_off_req = 1'b0;
        seg_bus.ready <= 1'b0;
        repeat (HOLD_OFF_CYCLES - 1) @(posedge clk);
      end else if (!no_idle && $urandom_range(99) < rx_idle_pct) begin
        seg_bus.ready <= 1'b0;
        repeat ($urandom_range(7)) @(posedge clk);
      end else begin
        seg_bus.ready <= 1'b1;
      end
    end
  end

  initial begin : watchdog
    int stuck_cycles;
    stuck_cycles = 0;
    while (stuck_cycles < WATCHDOG_LIMIT) begin
      @(posedge clk);
      if ((msg_bus.valid && msg_bus.ready) || (seg_bus.valid && seg_bus.ready) || cfg_write) begin
        stuck_cycles = 0;
      end else begin
        stuck_cycles++;
      end
    end
    $display("message_segmenter_core test failed");
    $finish;
  end

  task automatic send_byte(input logic [7:0] b, input bit typed, input beat_t want);
    int first;
    if (!no_idle && $urandom_range(99) < tx_idle_pct) begin
      msg_bus.valid <= 1'b0;
      repeat ($urandom_range(1, 8)) @(posedge clk);
    end
    msg_bus.valid     <= 1'b1;
    msg_bus.data_byte <= b;
    do @(posedge clk); while (!msg_bus.ready);
    first = pending_beats.size();
    if (segment_byte(b) > 0) begin
      live_bytes++;
      if (typed) begin
        pending_beats[first] = want;
      end
    end
  endtask

  // Bytes past the end produce no beat; they are dropped at the input and never enter the queue.
  task automatic wait_drained();
    msg_bus.valid <= 1'b0;
    while (pending_beats.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input reg_index_t idx, input logic [31:0] val);
    cfg_write <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
    cfg_write <= 1'b0;
    case (idx)
      REG_MESSAGE_LENGTH: cfg_len  = val;
      REG_ELEMENT_SIZE:   cfg_elem = val[ELEM_W-1:0];
      default: ;
    endcase
    byte_count = '0;
    packet_idx = '0;
    pkt_offset = '0;
    @(posedge clk);
  endtask

  // Mostly whole messages with random content; some are cut short, some overrun.
  task automatic run_phase(input int p);
    logic [31:0] len;
    logic [31:0] elem;
    int          n_send;
    int          roll;
    bit          write_elem;
    bit          elem_first;
    case (p)
      0: len = 32'd64;
      1: len = 32'd32;
      2: len = 32'd33;
      3: len = 32'd31;
      4: len = 32'hFFFF_FFFF;
      default: begin
        case ($urandom_range(9))
          0: len = 32'd32;
          1: len = 32'd64;
          2: len = 32'd0;
          3: len = 32'hFFFF_FFFF;
          4: len = $urandom | 32'h0000_1000;
          default: len = $urandom_range(1, 70);
        endcase
      end
    endcase
    elem = $urandom;
    case ($urandom_range(3))
      0: elem[15:0] = 16'h0000;
      1: elem[15:0] = 16'hFFFF;
      default: ;
    endcase
    if (len == 0) begin
      n_send = $urandom_range(1, 4);
    end else if (len > 100) begin
      n_send = $urandom_range(1, 40);
    end else begin
      n_send = len;
      roll = $urandom_range(99);
      if (roll < 15) begin
        n_send = $urandom_range(1, len);
      end else if (roll < 35) begin
        n_send = len + $urandom_range(1, 4);
      end
    end
    no_idle     = (live_bytes > ITEMS_TARGET - 40);
    tx_idle_pct = (p == 0) ? 0 : 10 * $urandom_range(0, 5);
    rx_idle_pct = 10 * $urandom_range(0, 5);
    write_elem  = (p < 5) || $urandom_range(1);
    elem_first  = $urandom_range(1);
    wait_drained();
    if (write_elem && elem_first) begin
      write_reg(REG_ELEMENT_SIZE, elem);
    end
    write_reg(REG_MESSAGE_LENGTH, len);
    if (write_elem && !elem_first) begin
      write_reg(REG_ELEMENT_SIZE, elem);
    end
    if (p == 0) begin
      hold_off_req = 1'b1;
    end
    repeat (n_send) send_byte(8'($urandom_range(255)), 1'b0, '0);
  endtask

  initial begin : stimulus
    rst               = 1'b1;
    cfg_write         = 1'b0;
    cfg_index         = REG_MESSAGE_LENGTH;
    cfg_data          = '0;
    msg_bus.valid     = 1'b0;
    msg_bus.data_byte = '0;
    repeat (11) @(posedge clk);
    rst <= 1'b0;
    foreach (directed[i]) begin
      if (directed[i].kind == ROW_WRITE) begin
        wait_drained();
        write_reg(directed[i].index, directed[i].value);
      end else begin
        send_byte(directed[i].value[7:0], directed[i].typed, directed[i].want);
      end
    end
    live_bytes = 0;
    for (int p = 0; live_bytes < ITEMS_TARGET; p++) begin
      run_phase(p);
    end
    wait_drained();
    if (mismatches == 0) begin
      $display("message_segmenter_core test passed");
    end else begin
      $display("message_segmenter_core test failed");
    end
    $finish;
  end

endmodule
